FILE: hw/rtl/oepf_pkg.sv
// shared types and constants of the oriented extreme point finder
`timescale 1ns / 1ps
`default_nettype none

package oepf_pkg;

  // fixed field widths
  localparam int unsigned TRIG_WIDTH    = 16;
  localparam int unsigned LIMIT_WIDTH   = 23;
  localparam int unsigned CFG_IDX_WIDTH = 3;
  localparam int unsigned NUM_EXT       = 4;

  // register indexes of the config port
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_WAYPOINT_X  = 3'd0,
    CFG_WAYPOINT_Y  = 3'd1,
    CFG_HEADING_COS = 3'd2,
    CFG_HEADING_SIN = 3'd3,
    CFG_RANGE_LIMIT = 3'd4
  } cfg_reg_e;

  // reset values of the config registers
  localparam logic signed [TRIG_WIDTH-1:0] HEADING_COS_RESET = 16'sd32767;
  localparam logic signed [TRIG_WIDTH-1:0] HEADING_SIN_RESET = 16'sd0;
  localparam logic [LIMIT_WIDTH-1:0]       RANGE_LIMIT_RESET = 23'd12800;

  // extreme slots, also the bit positions of found_mask
  localparam int unsigned EXT_FORE  = 0;
  localparam int unsigned EXT_REAR  = 1;
  localparam int unsigned EXT_LEFT  = 2;
  localparam int unsigned EXT_RIGHT = 3;

  // control that travels with an item between stages
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/oepf_if.sv
// channel interfaces: vertex in, extremes out, config writes
`timescale 1ns / 1ps
`default_nettype none

interface oepf_vertex_if #(
  parameter int unsigned COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface oepf_result_if #(
  parameter int unsigned COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] fore_x;
  logic signed [COORD_WIDTH-1:0] fore_y;
  logic signed [COORD_WIDTH-1:0] rear_x;
  logic signed [COORD_WIDTH-1:0] rear_y;
  logic signed [COORD_WIDTH-1:0] left_x;
  logic signed [COORD_WIDTH-1:0] left_y;
  logic signed [COORD_WIDTH-1:0] right_x;
  logic signed [COORD_WIDTH-1:0] right_y;
  logic [3:0]                    found_mask;

  modport source (output valid, fore_x, fore_y, rear_x, rear_y, left_x, left_y,
                  right_x, right_y, found_mask, input ready);
  modport sink   (input valid, fore_x, fore_y, rear_x, rear_y, left_x, left_y,
                  right_x, right_y, found_mask, output ready);
endinterface

interface oepf_cfg_if import oepf_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 24
) ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [DATA_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/oepf_cfg_regs.sv
// configuration registers: waypoint, heading and range limit
`timescale 1ns / 1ps
`default_nettype none

module oepf_cfg_regs import oepf_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  oepf_cfg_if.sink                      cfg_i,
  output logic signed [COORD_WIDTH-1:0] waypoint_x_o,
  output logic signed [COORD_WIDTH-1:0] waypoint_y_o,
  output logic signed [TRIG_WIDTH-1:0]  heading_cos_o,
  output logic signed [TRIG_WIDTH-1:0]  heading_sin_o,
  output logic [LIMIT_WIDTH-1:0]        range_limit_o
);

  logic signed [COORD_WIDTH-1:0] wp_x_q, wp_y_q;
  logic signed [TRIG_WIDTH-1:0]  cos_q, sin_q;
  logic [LIMIT_WIDTH-1:0]        limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_x_q  <= '0;
      wp_y_q  <= '0;
      cos_q   <= HEADING_COS_RESET;
      sin_q   <= HEADING_SIN_RESET;
      limit_q <= RANGE_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_WAYPOINT_X:  wp_x_q  <= cfg_i.data[COORD_WIDTH-1:0];
        CFG_WAYPOINT_Y:  wp_y_q  <= cfg_i.data[COORD_WIDTH-1:0];
        CFG_HEADING_COS: cos_q   <= cfg_i.data[TRIG_WIDTH-1:0];
        CFG_HEADING_SIN: sin_q   <= cfg_i.data[TRIG_WIDTH-1:0];
        CFG_RANGE_LIMIT: limit_q <= cfg_i.data[LIMIT_WIDTH-1:0];
        default: ; // unused indexes are ignored
      endcase
    end
  end

  assign waypoint_x_o  = wp_x_q;
  assign waypoint_y_o  = wp_y_q;
  assign heading_cos_o = cos_q;
  assign heading_sin_o = sin_q;
  assign range_limit_o = limit_q;

endmodule

`default_nettype wire

FILE: hw/rtl/oepf_rotate.sv
// three stage elastic pipe: offset, multiply, sum/shift/saturate
`timescale 1ns / 1ps
`default_nettype none

module oepf_rotate import oepf_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  oepf_vertex_if.sink                   vtx_i,
  input  logic signed [COORD_WIDTH-1:0] waypoint_x_i,
  input  logic signed [COORD_WIDTH-1:0] waypoint_y_i,
  input  logic signed [TRIG_WIDTH-1:0]  heading_cos_i,
  input  logic signed [TRIG_WIDTH-1:0]  heading_sin_i,
  output stage_ctrl_t                   rot_ctrl_o,
  input  logic                          rot_ready_i,
  output logic signed [COORD_WIDTH+1:0] forward_o,
  output logic signed [COORD_WIDTH+1:0] lateral_o,
  output logic signed [COORD_WIDTH-1:0] vertex_x_o,
  output logic signed [COORD_WIDTH-1:0] vertex_y_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;        // offset
  localparam int unsigned PW = DW + TRIG_WIDTH;        // product
  localparam int unsigned SW = PW + 1;                 // sum of two products
  localparam int unsigned EW = COORD_WIDTH + 2;        // saturated result

  // floor shift then clamp to EW bits signed
  function automatic logic signed [EW-1:0] sat_shift(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] sh;
    sh = v >>> TRIG_FRAC_BITS;
    if ((&sh[SW-1:EW-1]) || !(|sh[SW-1:EW-1])) begin
      return sh[EW-1:0];
    end else if (sh[SW-1]) begin
      return {1'b1, {(EW-1){1'b0}}};
    end else begin
      return {1'b0, {(EW-1){1'b1}}};
    end
  endfunction

  stage_ctrl_t s1_q, s2_q, s3_q;
  logic        ld1, ld2, ld3;

  logic signed [DW-1:0]          dx_q, dy_q;
  logic signed [PW-1:0]          cx_q, sy_q, cy_q, sx_q;
  logic signed [EW-1:0]          fwd_q, lat_q;
  logic signed [COORD_WIDTH-1:0] vx1_q, vy1_q, vx2_q, vy2_q, vx3_q, vy3_q;

  logic signed [DW-1:0] dx_d, dy_d;
  logic signed [PW-1:0] cx_d, sy_d, cy_d, sx_d;
  logic signed [SW-1:0] fwd_raw, lat_raw;

  // a stage loads when it is empty or its content moves on
  assign ld3 = !s3_q.valid || rot_ready_i;
  assign ld2 = !s2_q.valid || ld3;
  assign ld1 = !s1_q.valid || ld2;
  assign vtx_i.ready = ld1;

  assign dx_d = {vtx_i.vertex_x[COORD_WIDTH-1], vtx_i.vertex_x}
              - {waypoint_x_i[COORD_WIDTH-1], waypoint_x_i};
  assign dy_d = {vtx_i.vertex_y[COORD_WIDTH-1], vtx_i.vertex_y}
              - {waypoint_y_i[COORD_WIDTH-1], waypoint_y_i};

  assign cx_d = PW'(heading_cos_i) * PW'(dx_q);
  assign sy_d = PW'(heading_sin_i) * PW'(dy_q);
  assign cy_d = PW'(heading_cos_i) * PW'(dy_q);
  assign sx_d = PW'(heading_sin_i) * PW'(dx_q);

  assign fwd_raw = {cx_q[PW-1], cx_q} + {sy_q[PW-1], sy_q};
  assign lat_raw = {cy_q[PW-1], cy_q} - {sx_q[PW-1], sx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      if (ld1) begin
        s1_q.valid <= vtx_i.valid;
        s1_q.last  <= vtx_i.last_vertex;
      end
      if (ld2) s2_q <= s1_q;
      if (ld3) s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      vx1_q <= vtx_i.vertex_x;
      vy1_q <= vtx_i.vertex_y;
    end
    if (ld2) begin
      cx_q  <= cx_d;
      sy_q  <= sy_d;
      cy_q  <= cy_d;
      sx_q  <= sx_d;
      vx2_q <= vx1_q;
      vy2_q <= vy1_q;
    end
    if (ld3) begin
      fwd_q <= sat_shift(fwd_raw);
      lat_q <= sat_shift(lat_raw);
      vx3_q <= vx2_q;
      vy3_q <= vy2_q;
    end
  end

  assign rot_ctrl_o = s3_q;
  assign forward_o  = fwd_q;
  assign lateral_o  = lat_q;
  assign vertex_x_o = vx3_q;
  assign vertex_y_o = vy3_q;

endmodule

`default_nettype wire

FILE: hw/rtl/oepf_tracker.sv
// running extremes, found flags and the result register
`timescale 1ns / 1ps
`default_nettype none

module oepf_tracker import oepf_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [LIMIT_WIDTH-1:0]        range_limit_i,
  input  stage_ctrl_t                   rot_ctrl_i,
  output logic                          rot_ready_o,
  input  logic signed [COORD_WIDTH+1:0] forward_i,
  input  logic signed [COORD_WIDTH+1:0] lateral_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  oepf_result_if.source                 res_o
);

  localparam int unsigned EW = COORD_WIDTH + 2;
  // compare width covers both the extremes and the range limit
  localparam int unsigned MW = (EW > LIMIT_WIDTH + 1) ? EW : LIMIT_WIDTH + 1;

  logic signed [EW-1:0]          max_fwd_q, min_fwd_q, max_lat_q, min_lat_q;
  logic signed [EW-1:0]          max_fwd_d, min_fwd_d, max_lat_d, min_lat_d;
  logic signed [COORD_WIDTH-1:0] pt_x_q [NUM_EXT];
  logic signed [COORD_WIDTH-1:0] pt_y_q [NUM_EXT];
  logic signed [COORD_WIDTH-1:0] pt_x_d [NUM_EXT];
  logic signed [COORD_WIDTH-1:0] pt_y_d [NUM_EXT];
  logic [NUM_EXT-1:0]            found_q, found_d, found_upd;

  logic                          out_v_q, out_v_d;
  logic signed [COORD_WIDTH-1:0] out_x_q [NUM_EXT];
  logic signed [COORD_WIDTH-1:0] out_y_q [NUM_EXT];
  logic [NUM_EXT-1:0]            out_mask_q;

  logic signed [MW-1:0] lim_m, neg_lim_m, fwd_m, lat_m;
  logic signed [MW-1:0] b_fore, b_rear, b_left, b_right;
  logic [NUM_EXT-1:0]   hit;
  logic                 out_free, go, emit;

  assign out_free    = !out_v_q || res_o.ready;
  assign rot_ready_o = !rot_ctrl_i.last || out_free;
  assign go          = rot_ctrl_i.valid && rot_ready_o;
  assign emit        = go && rot_ctrl_i.last;

  assign lim_m     = $signed(MW'(range_limit_i));
  assign neg_lim_m = -lim_m;
  assign fwd_m     = MW'(forward_i);
  assign lat_m     = MW'(lateral_i);

  // an extreme not yet found compares against the current limit
  assign b_fore  = found_q[EXT_FORE]  ? MW'(max_fwd_q) : neg_lim_m;
  assign b_rear  = found_q[EXT_REAR]  ? MW'(min_fwd_q) : lim_m;
  assign b_left  = found_q[EXT_LEFT]  ? MW'(max_lat_q) : neg_lim_m;
  assign b_right = found_q[EXT_RIGHT] ? MW'(min_lat_q) : lim_m;

  // strict compares: ties keep the held extreme
  assign hit[EXT_FORE]  = fwd_m > b_fore;
  assign hit[EXT_REAR]  = fwd_m < b_rear;
  assign hit[EXT_LEFT]  = lat_m > b_left;
  assign hit[EXT_RIGHT] = lat_m < b_right;

  assign found_upd = found_q | hit;

  always_comb begin
    max_fwd_d = hit[EXT_FORE]  ? forward_i : max_fwd_q;
    min_fwd_d = hit[EXT_REAR]  ? forward_i : min_fwd_q;
    max_lat_d = hit[EXT_LEFT]  ? lateral_i : max_lat_q;
    min_lat_d = hit[EXT_RIGHT] ? lateral_i : min_lat_q;
    for (int k = 0; k < NUM_EXT; k++) begin
      pt_x_d[k] = hit[k] ? vertex_x_i : pt_x_q[k];
      pt_y_d[k] = hit[k] ? vertex_y_i : pt_y_q[k];
    end
    // the last vertex closes the polygon and clears the run
    found_d = rot_ctrl_i.last ? '0 : found_upd;
    out_v_d = out_v_q;
    if (res_o.ready) out_v_d = 1'b0;
    if (emit)        out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (go) found_q <= found_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      max_fwd_q <= max_fwd_d;
      min_fwd_q <= min_fwd_d;
      max_lat_q <= max_lat_d;
      min_lat_q <= min_lat_d;
      for (int k = 0; k < NUM_EXT; k++) begin
        pt_x_q[k] <= pt_x_d[k];
        pt_y_q[k] <= pt_y_d[k];
      end
    end
    if (emit) begin
      for (int k = 0; k < NUM_EXT; k++) begin
        out_x_q[k] <= found_upd[k] ? pt_x_d[k] : '0;
        out_y_q[k] <= found_upd[k] ? pt_y_d[k] : '0;
      end
      out_mask_q <= found_upd;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.fore_x     = out_x_q[EXT_FORE];
  assign res_o.fore_y     = out_y_q[EXT_FORE];
  assign res_o.rear_x     = out_x_q[EXT_REAR];
  assign res_o.rear_y     = out_y_q[EXT_REAR];
  assign res_o.left_x     = out_x_q[EXT_LEFT];
  assign res_o.left_y     = out_y_q[EXT_LEFT];
  assign res_o.right_x    = out_x_q[EXT_RIGHT];
  assign res_o.right_y    = out_y_q[EXT_RIGHT];
  assign res_o.found_mask = out_mask_q;

endmodule

`default_nettype wire

FILE: hw/rtl/oriented_extreme_point_finder_unit.sv
// top level of the oriented extreme point finder
//
// usage:
// - cfg_i writes waypoint_x, waypoint_y, heading_cos, heading_sin and
//   range_limit by index 0..4; ready is always high, other indexes are dropped
// - vtx_i takes one polygon vertex per item; last_vertex closes the polygon
// - res_o gives one item per polygon: the fore, rear, left and right extreme
//   vertices as they came in, plus found_mask; coordinates of an extreme that
//   was never found read zero
// - throughput is one vertex per cycle while no last vertex waits on a stalled
//   result; a last vertex passes through four registers on its way to res_o
//   (offset, multiply, sum/shift/saturate, then the extreme compare that
//   loads the result register)
// - the only feedback loop is the compare against the held extremes
// - when the receiver stalls, the result register holds; vertices that are
//   not last keep flowing, and a last vertex waits at the compare stage until
//   the result register frees up, which backs up the pipe behind it
// - reset empties the pipe, clears found flags and the result valid, and
//   puts the config registers at their reset values
`timescale 1ns / 1ps
`default_nettype none

module oriented_extreme_point_finder_unit import oepf_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  oepf_cfg_if.sink      cfg_i,
  oepf_vertex_if.sink   vtx_i,
  oepf_result_if.source res_o
);

  // config values
  logic signed [COORD_WIDTH-1:0] waypoint_x, waypoint_y;
  logic signed [TRIG_WIDTH-1:0]  heading_cos, heading_sin;
  logic [LIMIT_WIDTH-1:0]        range_limit;

  // rotated vertex handed to the tracker
  stage_ctrl_t                   rot_ctrl;
  logic                          rot_ready;
  logic signed [COORD_WIDTH+1:0] forward, lateral;
  logic signed [COORD_WIDTH-1:0] rot_vx, rot_vy;

  oepf_cfg_regs #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .waypoint_x_o  (waypoint_x),
    .waypoint_y_o  (waypoint_y),
    .heading_cos_o (heading_cos),
    .heading_sin_o (heading_sin),
    .range_limit_o (range_limit)
  );

  // offset by the waypoint, rotate by the heading, floor and saturate
  oepf_rotate #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vtx_i         (vtx_i),
    .waypoint_x_i  (waypoint_x),
    .waypoint_y_i  (waypoint_y),
    .heading_cos_i (heading_cos),
    .heading_sin_i (heading_sin),
    .rot_ctrl_o    (rot_ctrl),
    .rot_ready_i   (rot_ready),
    .forward_o     (forward),
    .lateral_o     (lateral),
    .vertex_x_o    (rot_vx),
    .vertex_y_o    (rot_vy)
  );

  // running extremes and the result register
  oepf_tracker #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .range_limit_i (range_limit),
    .rot_ctrl_i    (rot_ctrl),
    .rot_ready_o   (rot_ready),
    .forward_i     (forward),
    .lateral_i     (lateral),
    .vertex_x_i    (rot_vx),
    .vertex_y_i    (rot_vy),
    .res_o         (res_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/oepf_checker.sv
// port level checks of the finder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module oepf_checker #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   cfg_valid_i,
  input wire                   cfg_ready_i,
  input wire                   res_valid_i,
  input wire                   res_ready_i,
  input wire [COORD_WIDTH-1:0] fore_x_i,
  input wire [COORD_WIDTH-1:0] fore_y_i,
  input wire [COORD_WIDTH-1:0] rear_x_i,
  input wire [COORD_WIDTH-1:0] rear_y_i,
  input wire [COORD_WIDTH-1:0] left_x_i,
  input wire [COORD_WIDTH-1:0] left_y_i,
  input wire [COORD_WIDTH-1:0] right_x_i,
  input wire [COORD_WIDTH-1:0] right_y_i,
  input wire [3:0]             found_mask_i
);

  // no result is shown while in reset
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  // an extreme that was not found reports zero coordinates
  a_missing_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |->
      (found_mask_i[0] || (fore_x_i == '0 && fore_y_i == '0)) &&
      (found_mask_i[1] || (rear_x_i == '0 && rear_y_i == '0)) &&
      (found_mask_i[2] || (left_x_i == '0 && left_y_i == '0)) &&
      (found_mask_i[3] || (right_x_i == '0 && right_y_i == '0)))
    else $error("missing extreme with nonzero coordinates");

  // config writes are never back-pressured
  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config port stalled");

  // a stalled result holds its payload
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(found_mask_i) &&
      $stable(fore_x_i) && $stable(fore_y_i) && $stable(rear_x_i) &&
      $stable(rear_y_i) && $stable(left_x_i) && $stable(left_y_i) &&
      $stable(right_x_i) && $stable(right_y_i))
    else $error("stalled result changed");

endmodule

bind oriented_extreme_point_finder_unit oepf_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_oepf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .fore_x_i     (res_o.fore_x),
  .fore_y_i     (res_o.fore_y),
  .rear_x_i     (res_o.rear_x),
  .rear_y_i     (res_o.rear_y),
  .left_x_i     (res_o.left_x),
  .left_y_i     (res_o.left_y),
  .right_x_i    (res_o.right_x),
  .right_y_i    (res_o.right_y),
  .found_mask_i (res_o.found_mask)
);

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench of the oriented extreme point finder unit
`timescale 1ns / 1ps

module testbench;
  import oepf_pkg::*;

  localparam int unsigned COORD_W        = 24;
  localparam int unsigned TRIG_FRAC      = 15;
  localparam int unsigned CFG_W          = 24;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PHASE_VERTICES = 72;
  // pipe is four stages deep, leave some margin on top
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned PRINT_CAP      = 100;

  typedef logic signed [COORD_W-1:0]    coord_t;
  typedef logic signed [COORD_W+1:0]    span_t;
  typedef logic signed [TRIG_WIDTH-1:0] trig_t;

  localparam coord_t C_MAX = coord_t'((64'sd1 <<< (COORD_W - 1)) - 1);
  localparam coord_t C_MIN = coord_t'(-(64'sd1 <<< (COORD_W - 1)));
  localparam trig_t  TRIG_MAX = 16'sh7fff;
  localparam trig_t  TRIG_MIN = 16'sh8000;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = '1;
  localparam longint SPAN_HI = (64'sd1 <<< (COORD_W + 1)) - 1;
  localparam longint SPAN_LO = -SPAN_HI - 1;
  // indexes the block has no register behind
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_LO = CFG_IDX_WIDTH'(CFG_RANGE_LIMIT + 1);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_HI = '1;

  // one result item: extreme vertices indexed by slot, plus the found mask
  typedef struct packed {
    logic [NUM_EXT-1:0][COORD_W-1:0] x;
    logic [NUM_EXT-1:0][COORD_W-1:0] y;
    logic [NUM_EXT-1:0]              mask;
  } extremes_t;

  typedef enum bit {ROW_VERTEX, ROW_WRITE} row_kind_e;

  // one line of the directed plan; want is used only where typed is set
  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_WIDTH-1:0] idx;
    logic [CFG_W-1:0]         data;
    coord_t                   x;
    coord_t                   y;
    bit                       last;
    bit                       typed;
    extremes_t                want;
  } stim_row_t;

  bit   clk_i;
  logic rst_ni;

  oepf_cfg_if    #(.DATA_WIDTH(CFG_W))     cfg_if ();
  oepf_vertex_if #(.COORD_WIDTH(COORD_W))  vtx_if ();
  oepf_result_if #(.COORD_WIDTH(COORD_W))  res_if ();

  oriented_extreme_point_finder_unit #(
    .COORD_WIDTH   (COORD_W),
    .TRIG_FRAC_BITS(TRIG_FRAC)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .vtx_i (vtx_if),
    .res_o (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // register mirror and running extremes of the predictor
  coord_t                  wp_x;
  coord_t                  wp_y;
  trig_t                   hd_cos;
  trig_t                   hd_sin;
  logic [LIMIT_WIDTH-1:0]  lim_q;
  span_t                   top_fwd;
  span_t                   low_fwd;
  span_t                   top_lat;
  span_t                   low_lat;
  extremes_t               held;

  stim_row_t plan[$];              // directed plan, walked in order
  extremes_t pending_extremes[$];  // results owed by the block, oldest first
  extremes_t listed_extremes[$];   // results typed into the plan by hand
  bit        item_typed;           // travels with the vertex on the channel
  bit        calm;                 // no idling on either side
  bit        hold_req;             // asks the result side for a long stall
  int        mismatches;
  int        quiet_cycles;
  string     ext_name[NUM_EXT] = '{"fore", "rear", "left", "right"};

  function automatic longint clip_span(input longint v);
    return (v > SPAN_HI) ? SPAN_HI : ((v < SPAN_LO) ? SPAN_LO : v);
  endfunction

  function automatic coord_t to_coord(input longint v);
    return (v > longint'(C_MAX)) ? C_MAX : ((v < longint'(C_MIN)) ? C_MIN : coord_t'(v));
  endfunction

  // start a new polygon: bounds go back to the range limit, nothing found
  function automatic void clear_extremes();
    top_fwd = span_t'(-longint'(lim_q));
    low_fwd = span_t'(longint'(lim_q));
    top_lat = span_t'(-longint'(lim_q));
    low_lat = span_t'(longint'(lim_q));
    held    = '0;
  endfunction

  function automatic void reset_mirror();
    wp_x   = '0;
    wp_y   = '0;
    hd_cos = HEADING_COS_RESET;
    hd_sin = HEADING_SIN_RESET;
    lim_q  = RANGE_LIMIT_RESET;
    clear_extremes();
  endfunction

  function automatic void mirror_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    case (idx)
      CFG_WAYPOINT_X:  wp_x   = coord_t'(data);
      CFG_WAYPOINT_Y:  wp_y   = coord_t'(data);
      CFG_HEADING_COS: hd_cos = data[TRIG_WIDTH-1:0];
      CFG_HEADING_SIN: hd_sin = data[TRIG_WIDTH-1:0];
      CFG_RANGE_LIMIT: lim_q  = data[LIMIT_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  // rotate one vertex into the waypoint frame and update the extremes;
  // returns 1 with the finished polygon's extremes on the last vertex
  function automatic bit track_vertex(input coord_t vx, input coord_t vy, input logic last,
                                      output extremes_t outcome);
    longint dx, dy, fwd, lat, lim;
    logic [NUM_EXT-1:0] hit;
    int k;
    dx  = longint'(vx) - longint'(wp_x);
    dy  = longint'(vy) - longint'(wp_y);
    // arithmetic shift of a signed value rounds toward minus infinity
    fwd = clip_span((longint'(hd_cos) * dx + longint'(hd_sin) * dy) >>> TRIG_FRAC);
    lat = clip_span((longint'(hd_cos) * dy - longint'(hd_sin) * dx) >>> TRIG_FRAC);
    lim = longint'(lim_q);
    // an extreme not yet found compares against the limit as it is now
    hit[EXT_FORE]  = fwd > (held.mask[EXT_FORE]  ? longint'(top_fwd) : -lim);
    hit[EXT_REAR]  = fwd < (held.mask[EXT_REAR]  ? longint'(low_fwd) : lim);
    hit[EXT_LEFT]  = lat > (held.mask[EXT_LEFT]  ? longint'(top_lat) : -lim);
    hit[EXT_RIGHT] = lat < (held.mask[EXT_RIGHT] ? longint'(low_lat) : lim);
    if (hit[EXT_FORE])  top_fwd = span_t'(fwd);
    if (hit[EXT_REAR])  low_fwd = span_t'(fwd);
    if (hit[EXT_LEFT])  top_lat = span_t'(lat);
    if (hit[EXT_RIGHT]) low_lat = span_t'(lat);
    for (k = 0; k < NUM_EXT; k++) begin
      if (hit[k]) begin
        held.x[k]    = vx;
        held.y[k]    = vy;
        held.mask[k] = 1'b1;
      end
    end
    outcome = held;
    if (last) clear_extremes();
    return last;
  endfunction

  function automatic extremes_t corners(input coord_t fx, fy, rx, ry, lx, ly, tx, ty,
                                        input logic [NUM_EXT-1:0] m);
    extremes_t r;
    r.x[EXT_FORE]  = fx;
    r.y[EXT_FORE]  = fy;
    r.x[EXT_REAR]  = rx;
    r.y[EXT_REAR]  = ry;
    r.x[EXT_LEFT]  = lx;
    r.y[EXT_LEFT]  = ly;
    r.x[EXT_RIGHT] = tx;
    r.y[EXT_RIGHT] = ty;
    r.mask         = m;
    return r;
  endfunction

  function automatic stim_row_t vertex_row(input coord_t x, input coord_t y, input bit last);
    stim_row_t r;
    r       = '{kind: ROW_VERTEX, default: '0};
    r.x     = x;
    r.y     = y;
    r.last  = last;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input coord_t x, input coord_t y,
                                            input extremes_t want);
    stim_row_t r;
    r       = vertex_row(x, y, 1'b1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_WIDTH-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    stim_row_t r;
    r      = '{kind: ROW_WRITE, default: '0};
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // add one line at the end of the directed plan
  function automatic void add_row(input stim_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // offer one vertex, with random idle cycles ahead of it, until taken
  task automatic send_vertex(input coord_t x, input coord_t y, input bit last, input bit typed);
    while (!calm && $urandom_range(99) < 17) begin
      vtx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx_if.valid       <= 1'b1;
    vtx_if.vertex_x    <= x;
    vtx_if.vertex_y    <= y;
    vtx_if.last_vertex <= last;
    item_typed         <= typed;
    do @(posedge clk_i); while (!vtx_if.ready);
  endtask

  // the caller lowers valid once a batch of writes is done
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // stop sending, wait for every owed result, then let the pipe run dry
  task automatic quiesce();
    vtx_if.valid <= 1'b0;
    while (pending_extremes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all five registers; bits above each register's width are noise
  task automatic load_setting(input coord_t wx, input coord_t wy, input trig_t c,
                              input trig_t s, input logic [LIMIT_WIDTH-1:0] lim);
    logic [CFG_W-1:0] word;
    quiesce();
    write_reg(CFG_WAYPOINT_X, wx);
    write_reg(CFG_WAYPOINT_Y, wy);
    word = CFG_W'($urandom());
    word[TRIG_WIDTH-1:0] = c;
    write_reg(CFG_HEADING_COS, word);
    word = CFG_W'($urandom());
    word[TRIG_WIDTH-1:0] = s;
    write_reg(CFG_HEADING_SIN, word);
    word = CFG_W'($urandom());
    word[LIMIT_WIDTH-1:0] = lim;
    write_reg(CFG_RANGE_LIMIT, word);
    cfg_if.valid <= 1'b0;
  endtask

  // register writes land in the mirror as the block takes them
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready)
      mirror_write(cfg_if.index, cfg_if.data);
  end

  // every accepted vertex runs through the predictor; a last vertex owes a result,
  // taken from the plan where it was typed in by hand
  always @(posedge clk_i) begin : take_vertex
    extremes_t outcome;
    if (rst_ni && vtx_if.valid && vtx_if.ready) begin
      if (track_vertex(vtx_if.vertex_x, vtx_if.vertex_y, vtx_if.last_vertex, outcome))
        pending_extremes.insert(pending_extremes.size(),
                                item_typed ? listed_extremes.pop_front() : outcome);
    end
  end

  // compare each result item field by field with the oldest owed one
  always @(posedge clk_i) begin : check_result
    extremes_t got, want;
    int k;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.x[EXT_FORE]  = res_if.fore_x;
      got.y[EXT_FORE]  = res_if.fore_y;
      got.x[EXT_REAR]  = res_if.rear_x;
      got.y[EXT_REAR]  = res_if.rear_y;
      got.x[EXT_LEFT]  = res_if.left_x;
      got.y[EXT_LEFT]  = res_if.left_y;
      got.x[EXT_RIGHT] = res_if.right_x;
      got.y[EXT_RIGHT] = res_if.right_y;
      got.mask         = res_if.found_mask;
      if (pending_extremes.size() == 0) begin
        report_mismatch("result item with none owed, found_mask", got.mask, 0);
      end else begin
        want = pending_extremes.pop_front();
        for (k = 0; k < NUM_EXT; k++) begin
          if (got.x[k] !== want.x[k])
            report_mismatch({ext_name[k], "_x"}, $signed(got.x[k]), $signed(want.x[k]));
          if (got.y[k] !== want.y[k])
            report_mismatch({ext_name[k], "_y"}, $signed(got.y[k]), $signed(want.y[k]));
        end
        if (got.mask !== want.mask)
          report_mismatch("found_mask", got.mask, want.mask);
      end
    end
  end

  // result side: random stalls, a calm stretch, and one long hold-off
  initial begin : result_sink
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  // watchdog: too long without any handshake on any channel
  always @(posedge clk_i) begin
    if ((vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("oriented_extreme_point_finder_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    bit          prev_write;
    int          poly_left;
    int          max_poly;
    longint      off_range;
    coord_t      vx, vy;
    coord_t      wx, wy;
    logic [LIMIT_WIDTH-1:0] lim;

    vtx_if.valid       = 1'b0;
    vtx_if.vertex_x    = '0;
    vtx_if.vertex_y    = '0;
    vtx_if.last_vertex = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    item_typed         = 1'b0;
    calm               = 1'b0;
    hold_req           = 1'b0;
    mismatches         = 0;
    quiet_cycles       = 0;
    reset_mirror();
    #1 rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: waypoint at the origin, heading along x, limit 12800
    // vertex on the waypoint is every extreme at once
    add_row(checked_row(0, 0, corners(0, 0, 0, 0, 0, 0, 0, 0, 4'b1111)));
    // far ahead: not rearward, lateral zero still beats both bounds
    add_row(checked_row(C_MAX, 0,
                        corners(C_MAX, 0, 0, 0, C_MAX, 0, C_MAX, 0, 4'b1101)));
    // far behind and to the right
    add_row(checked_row(C_MIN, C_MIN,
                        corners(0, 0, C_MIN, C_MIN, 0, 0, C_MIN, C_MIN, 4'b1010)));
    // far to the left
    add_row(checked_row(0, C_MAX,
                        corners(0, C_MAX, 0, C_MAX, 0, C_MAX, 0, 0, 4'b0111)));
    // forward lands exactly on minus the limit: a tie does not count as found
    add_row(checked_row(-12800, 0,
                        corners(0, 0, -12800, 0, -12800, 0, -12800, 0, 4'b1110)));
    // forward lands exactly on the limit
    add_row(checked_row(12801, 0,
                        corners(12801, 0, 0, 0, 12801, 0, 12801, 0, 4'b1101)));
    // equal forward keeps the first vertex, larger lateral replaces left only
    add_row(vertex_row(100, 0, 1'b0));
    add_row(checked_row(100, 3,
                        corners(100, 0, 100, 0, 100, 3, 100, 0, 4'b1111)));
    add_row(vertex_row(-300, 7000, 1'b0));
    add_row(vertex_row(250, -9000, 1'b0));
    add_row(vertex_row(40, 40, 1'b1));
    // zero limit and a vertex on the waypoint: nothing found at all
    add_row(write_row(CFG_RANGE_LIMIT, 0));
    add_row(checked_row(0, 0, corners(0, 0, 0, 0, 0, 0, 0, 0, 4'b0000)));
    // limit changes while a polygon is open
    add_row(vertex_row(5, 0, 1'b0));
    add_row(write_row(CFG_RANGE_LIMIT, 100));
    add_row(vertex_row(-50, 20, 1'b1));
    // extreme waypoint, inconsistent cosine and sine, widest limit
    add_row(write_row(CFG_WAYPOINT_X, C_MIN));
    add_row(write_row(CFG_WAYPOINT_Y, C_MAX));
    add_row(write_row(CFG_HEADING_COS, 24'hff8000));
    add_row(write_row(CFG_HEADING_SIN, 24'h008000));
    add_row(write_row(CFG_RANGE_LIMIT, 24'hffffff));
    add_row(vertex_row(C_MAX, C_MIN, 1'b0));
    add_row(vertex_row(C_MIN, C_MAX, 1'b0));
    add_row(vertex_row(C_MAX, C_MAX, 1'b1));
    // writes to unused indexes must change nothing
    add_row(write_row(CFG_SPARE_LO, 24'hffffff));
    add_row(write_row(CFG_SPARE_HI, 24'hffffff));
    add_row(vertex_row(1234, -4321, 1'b1));

    prev_write = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!prev_write) quiesce();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (prev_write) cfg_if.valid <= 1'b0;
        if (plan[i].typed) listed_extremes.insert(listed_extremes.size(), plan[i].want);
        send_vertex(plan[i].x, plan[i].y, plan[i].last, plan[i].typed);
      end
      prev_write = (plan[i].kind == ROW_WRITE);
    end

    // random polygons over a series of settings; a polygon may run across a
    // phase boundary, so new settings also land in the middle of a polygon
    poly_left = 0;
    vx = 0;
    vy = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_setting(0, 0, HEADING_COS_RESET, HEADING_SIN_RESET, RANGE_LIMIT_RESET);
        1: load_setting(C_MIN, C_MIN, TRIG_MIN, TRIG_MIN, LIMIT_MAX);
        2: load_setting(C_MAX, C_MAX, TRIG_MAX, TRIG_MAX, '0);
        default: begin
          wx = $urandom_range(1) ? coord_t'($urandom()) : coord_t'(int'($urandom_range(4000)) - 2000);
          wy = $urandom_range(1) ? coord_t'($urandom()) : coord_t'(int'($urandom_range(4000)) - 2000);
          case ($urandom_range(3))
            0:       lim = '0;
            1:       lim = LIMIT_MAX;
            2:       lim = LIMIT_WIDTH'($urandom_range(20000));
            default: lim = LIMIT_WIDTH'($urandom());
          endcase
          load_setting(wx, wy, trig_t'($urandom()), trig_t'($urandom()), lim);
        end
      endcase
      calm = (p == 4);
      // short polygons during the hold-off so results pile up behind the stall
      max_poly = (p == 6) ? 2 : 8;
      if (p == 6) hold_req = 1'b1;
      for (int n = 0; n < PHASE_VERTICES; n++) begin
        if (poly_left == 0)
          poly_left = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(max_poly, 1);
        off_range = longint'(lim_q) + 2000;
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // near the waypoint, around the range limit
            vx = to_coord(longint'(wp_x) + longint'($urandom_range(32'(2 * off_range)))
                          - off_range);
            vy = to_coord(longint'(wp_y) + longint'($urandom_range(32'(2 * off_range)))
                          - off_range);
          end
          4, 5, 6: begin
            vx = coord_t'($urandom());
            vy = coord_t'($urandom());
          end
          7: ;  // same vertex again, ties on every axis
          8: vy = coord_t'($urandom());
          default: begin
            vx = $urandom_range(1) ? C_MAX : C_MIN;
            vy = $urandom_range(1) ? C_MAX : C_MIN;
          end
        endcase
        poly_left--;
        send_vertex(vx, vy, poly_left == 0, 1'b0);
      end
    end
    // close the last polygon so its result is checked too
    if (poly_left != 0) send_vertex(vx, vy, 1'b1, 1'b0);

    vtx_if.valid <= 1'b0;
    while (pending_extremes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("oriented_extreme_point_finder_unit verification clean");
    else
      $display("oriented_extreme_point_finder_unit verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/oepf_pkg.sv
hw/rtl/oepf_if.sv
hw/rtl/oepf_cfg_regs.sv
hw/rtl/oepf_rotate.sv
hw/rtl/oepf_tracker.sv
hw/rtl/oriented_extreme_point_finder_unit.sv
hw/rtl/oepf_checker.sv
tb/testbench.sv
